/* sv/potts_lattice_flip_engine_macros.svh */
// assertion macros used by the lattice flip engine top module
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef POTTS_LATTICE_FLIP_ENGINE_MACROS_SVH
`define POTTS_LATTICE_FLIP_ENGINE_MACROS_SVH

// same-cycle implication, disabled while the active-low reset is applied
`define PFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pfe assertion failed");

// next-cycle implication, disabled while the active-low reset is applied
`define PFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pfe assertion failed");

`endif

/* sv/pfe_pkg.sv */
// shared types, codes and tables of the lattice flip engine
// no dependencies; imported by the divider, the neighbour unit, the top module and the testbench
package pfe_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FLIP  = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    // result status codes
    localparam logic [3:0] ST_WRITTEN = 4'd0;
    localparam logic [3:0] ST_READ    = 4'd1;
    localparam logic [3:0] ST_FLIPPED = 4'd2;
    localparam logic [3:0] ST_UNIFORM = 4'd3;
    localparam logic [3:0] ST_VOID    = 4'd4;
    localparam logic [3:0] ST_SAME    = 4'd5;
    localparam logic [3:0] ST_REJECT  = 4'd6;
    localparam logic [3:0] ST_SKIPPED = 4'd7;
    localparam logic [3:0] ST_RANGE   = 4'd8;

    // configuration register indexes
    localparam logic [2:0] REG_DIM_X = 3'd0;
    localparam logic [2:0] REG_DIM_Y = 3'd1;
    localparam logic [2:0] REG_DIM_Z = 3'd2;
    localparam logic [2:0] REG_WRAP  = 3'd3;
    localparam logic [2:0] REG_MASK  = 3'd4;

    // neighbourhood sizes
    localparam logic [4:0] NB_LAST_2D = 5'd7;
    localparam logic [4:0] NB_LAST_3D = 5'd25;
    localparam logic [4:0] NB_MAX     = 5'd26;
    localparam int         NB_DEPTH   = 26;

    // width of a linear index before the store bound check
    localparam int IDXW = 31;

    // axis step codes
    localparam logic [1:0] STEP_Z = 2'd0;
    localparam logic [1:0] STEP_P = 2'd1;
    localparam logic [1:0] STEP_N = 2'd2;

    typedef struct packed {
        logic [1:0] sx;
        logic [1:0] sy;
        logic [1:0] sz;
    } step_t;

    typedef struct packed {
        logic        start;
        logic [14:0] dividend;
        logic [10:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [14:0] quot;
        logic [10:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic        two_d;
        logic        wrap;
        logic [10:0] dx;
        logic [10:0] dy;
        logic [10:0] dz;
        logic [20:0] xy;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [9:0]  z;
        logic [4:0]  k;
    } nbr_ctx_t;

    typedef struct packed {
        logic            ok;
        logic [IDXW-1:0] index;
    } nbr_rsp_t;

    // size register as used: zero acts as one, above 1024 acts as 1024
    function automatic logic [10:0] eff_dim(input logic [10:0] d);
        logic [10:0] r;
        r = d;
        if (d == 11'd0) r = 11'd1;
        else if (d > 11'd1024) r = 11'd1024;
        return r;
    endfunction

    // neighbour offset table, 8 entries in 2D and 26 in 3D
    function automatic step_t nb_step(input logic two_d, input logic [4:0] k);
        step_t s;
        s = {STEP_Z, STEP_Z, STEP_Z};
        if (two_d) begin
            unique case (k[2:0])
                3'd0: s = {STEP_P, STEP_Z, STEP_Z};
                3'd1: s = {STEP_N, STEP_Z, STEP_Z};
                3'd2: s = {STEP_Z, STEP_P, STEP_Z};
                3'd3: s = {STEP_Z, STEP_N, STEP_Z};
                3'd4: s = {STEP_P, STEP_P, STEP_Z};
                3'd5: s = {STEP_N, STEP_P, STEP_Z};
                3'd6: s = {STEP_P, STEP_N, STEP_Z};
                default: s = {STEP_N, STEP_N, STEP_Z};
            endcase
        end else begin
            unique case (k)
                5'd0:  s = {STEP_P, STEP_Z, STEP_Z};
                5'd1:  s = {STEP_N, STEP_Z, STEP_Z};
                5'd2:  s = {STEP_Z, STEP_P, STEP_Z};
                5'd3:  s = {STEP_Z, STEP_N, STEP_Z};
                5'd4:  s = {STEP_Z, STEP_Z, STEP_P};
                5'd5:  s = {STEP_Z, STEP_Z, STEP_N};
                5'd6:  s = {STEP_P, STEP_P, STEP_Z};
                5'd7:  s = {STEP_N, STEP_P, STEP_Z};
                5'd8:  s = {STEP_P, STEP_N, STEP_Z};
                5'd9:  s = {STEP_N, STEP_N, STEP_Z};
                5'd10: s = {STEP_P, STEP_Z, STEP_P};
                5'd11: s = {STEP_P, STEP_Z, STEP_N};
                5'd12: s = {STEP_N, STEP_Z, STEP_P};
                5'd13: s = {STEP_N, STEP_Z, STEP_N};
                5'd14: s = {STEP_Z, STEP_P, STEP_P};
                5'd15: s = {STEP_Z, STEP_P, STEP_N};
                5'd16: s = {STEP_Z, STEP_N, STEP_P};
                5'd17: s = {STEP_Z, STEP_N, STEP_N};
                5'd18: s = {STEP_P, STEP_P, STEP_P};
                5'd19: s = {STEP_P, STEP_P, STEP_N};
                5'd20: s = {STEP_P, STEP_N, STEP_P};
                5'd21: s = {STEP_P, STEP_N, STEP_N};
                5'd22: s = {STEP_N, STEP_P, STEP_P};
                5'd23: s = {STEP_N, STEP_P, STEP_N};
                5'd24: s = {STEP_N, STEP_N, STEP_P};
                default: s = {STEP_N, STEP_N, STEP_N};
            endcase
        end
        return s;
    endfunction

endpackage

/* sv/pfe_ram.sv */
// generic single-port ram with registered read
// no dependencies; holds the lattice labels and mask bits
module pfe_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

/* sv/pfe_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on pfe_pkg for the request and response structs
module pfe_div
    import pfe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [14:0] quot_reg, quot_next;
    logic [10:0] rem_reg, rem_next;
    logic [11:0] shifted;

    // one shift and trial subtract per cycle
    always_comb begin
        shifted   = {rem_reg, quot_reg[14]};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            cnt_next  = 4'd15;
            quot_next = req.dividend;
            rem_next  = 11'd0;
        end else if (cnt_reg != 4'd0) begin
            cnt_next  = cnt_reg - 4'd1;
            done_next = (cnt_reg == 4'd1);
            if (shifted >= {1'b0, req.divisor}) begin
                rem_next  = 11'(shifted - {1'b0, req.divisor});
                quot_next = {quot_reg[13:0], 1'b1};
            end else begin
                rem_next  = shifted[10:0];
                quot_next = {quot_reg[13:0], 1'b0};
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp = '{done: done_reg, quot: quot_reg, rem: rem_reg};

endmodule

/* sv/pfe_nbr.sv */
// neighbour address unit: axis moves, then index products, then sum and bound check
// depends on pfe_pkg for the offset table and context structs
module pfe_nbr
    import pfe_pkg::*;
#(
    parameter int MAX_CELLS = 32768
) (
    input  logic     aclk,
    input  nbr_ctx_t ctx,
    output nbr_rsp_t rsp
);

    localparam logic [IDXW-1:0] MAX_W = IDXW'(MAX_CELLS);

    typedef struct packed {
        logic       ok;
        logic [9:0] val;
    } axis_t;

    // one coordinate moved by one step, wrapped or clipped
    function automatic axis_t move_axis(input logic [9:0] c, input logic [1:0] s,
                                        input logic [10:0] n, input logic wrap);
        axis_t a;
        a.ok  = 1'b1;
        a.val = c;
        case (s)
            STEP_P: begin
                if ({1'b0, c} + 11'd1 >= n) begin
                    a.ok  = wrap;
                    a.val = 10'd0;
                end else begin
                    a.val = c + 10'd1;
                end
            end
            STEP_N: begin
                if (c == 10'd0) begin
                    a.ok  = wrap;
                    a.val = 10'(n - 11'd1);
                end else begin
                    a.val = c - 10'd1;
                end
            end
            default: a.val = c;
        endcase
        return a;
    endfunction

    step_t       st;
    axis_t       ax, ay, az;
    logic        ok1_reg, ok2_reg;
    logic [9:0]  nx1_reg, ny1_reg, nz1_reg, nx2_reg;
    logic [30:0] pz_reg;
    logic [20:0] py_reg;
    logic [IDXW-1:0] sum;

    // stage one: coordinates of the neighbour
    always_comb begin
        st = nb_step(ctx.two_d, ctx.k);
        ax = move_axis(ctx.x, st.sx, ctx.dx, ctx.wrap);
        ay = move_axis(ctx.y, st.sy, ctx.dy, ctx.wrap);
        az = move_axis(ctx.z, st.sz, ctx.dz, ctx.wrap);
    end

    always_ff @(posedge aclk) begin
        ok1_reg <= ax.ok && ay.ok && az.ok;
        nx1_reg <= ax.val;
        ny1_reg <= ay.val;
        nz1_reg <= az.val;
    end

    // stage two: plane and row products
    always_ff @(posedge aclk) begin
        ok2_reg <= ok1_reg;
        nx2_reg <= nx1_reg;
        pz_reg  <= nz1_reg * ctx.xy;
        py_reg  <= ny1_reg * ctx.dx;
    end

    // linear index and store bound
    assign sum = pz_reg + IDXW'(py_reg) + IDXW'(nx2_reg);
    assign rsp = '{ok: ok2_reg && (sum < MAX_W), index: sum};

endmodule

/* sv/potts_lattice_flip_engine.sv */
// lattice flip engine: one transaction at a time. a flip is the longest command, its length set
// by the serial neighbour scan over the 8 or 26 neighbour offsets through the single lattice ram
// port and the one-bit-per-cycle divider used for coordinates and the neighbour pick.
// synchronous active-low reset restores the configuration defaults and clears the flip
// counter and handshake state; lattice contents are not cleared.
`include "potts_lattice_flip_engine_macros.svh"

module potts_lattice_flip_engine
    import pfe_pkg::*;
#(
    parameter int MAX_CELLS  = 32768,
    parameter int LABEL_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [14:0] s_cell_index,
    input  logic [15:0] s_cell_label,
    input  logic        s_cell_mask,
    input  logic [4:0]  s_neighbor_choice,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [15:0] m_label_out,
    output logic [31:0] m_flip_count,
    output logic [4:0]  m_neighbor_count,
    output logic signed [5:0] m_energy_twice
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int LB = LABEL_BITS;
    localparam logic [IDXW-1:0] MAX_W = IDXW'(MAX_CELLS);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_XY   = 5'd1;
    localparam logic [4:0] S_TOT  = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_SITE = 5'd4;
    localparam logic [4:0] S_DIV1 = 5'd5;
    localparam logic [4:0] S_DIV2 = 5'd6;
    localparam logic [4:0] S_NB1  = 5'd7;
    localparam logic [4:0] S_NB2  = 5'd8;
    localparam logic [4:0] S_NB3  = 5'd9;
    localparam logic [4:0] S_NB4  = 5'd10;
    localparam logic [4:0] S_EVAL = 5'd11;
    localparam logic [4:0] S_MOD  = 5'd12;
    localparam logic [4:0] S_CAND = 5'd13;
    localparam logic [4:0] S_ENER = 5'd14;
    localparam logic [4:0] S_DEC  = 5'd15;
    localparam logic [4:0] S_EMIT = 5'd16;

    // configuration registers
    logic [10:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic        wrap_reg, use_mask_reg;
    logic [10:0] dx, dy, dz;
    logic        cfg_we;

    // control and datapath registers
    logic [4:0]  state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [14:0] idx_reg, idx_next;
    logic [LB-1:0] lab_reg, lab_next;
    logic        msk_reg, msk_next;
    logic [4:0]  choice_reg, choice_next;
    logic [20:0] xy_reg, xy_next;
    logic [30:0] total_reg, total_next;
    logic [LB-1:0] spin_reg, spin_next;
    logic        smask_reg, smask_next;
    logic [9:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]  k_reg, k_next;
    logic [4:0]  ncount_reg, ncount_next;
    logic [4:0]  same_reg, same_next;
    logic [4:0]  ptr_reg, ptr_next;
    logic [4:0]  ccount_reg, ccount_next;
    logic [LB-1:0] cand_reg, cand_next;
    logic [3:0]  res_status_reg, res_status_next;
    logic [LB-1:0] res_label_reg, res_label_next;
    logic signed [5:0] res_e2_reg, res_e2_next;
    logic [31:0] flip_cnt_reg, flip_cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  m_status_reg;
    logic [15:0] m_label_reg;
    logic [31:0] m_flip_reg;
    logic [4:0]  m_ncount_reg;
    logic signed [5:0] m_e2_reg;
    logic        m_load;

    // neighbour label buffer
    logic [LB-1:0] nb_lab_reg [NB_DEPTH];
    logic          nb_we;
    logic [LB-1:0] nb_rd;

    // lattice ram
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [LB:0]   ram_wdata, ram_rdata;
    logic [LB-1:0] rd_label;
    logic          rd_mask;

    // shared units
    div_req_t div_req;
    div_rsp_t div_rsp;
    nbr_ctx_t nbr_ctx;
    nbr_rsp_t nbr_rsp;

    logic        two_d, in_range, accept;
    logic [4:0]  k_last;
    logic signed [5:0] e2;

    pfe_ram #(.WIDTH(LB + 1), .DEPTH(MAX_CELLS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    pfe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pfe_nbr #(.MAX_CELLS(MAX_CELLS)) u_nbr (
        .aclk (aclk),
        .ctx  (nbr_ctx),
        .rsp  (nbr_rsp)
    );

    // apb register file
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

    always_comb begin
        unique case (paddr[4:2])
            REG_DIM_X: prdata = {21'd0, dim_x_reg};
            REG_DIM_Y: prdata = {21'd0, dim_y_reg};
            REG_DIM_Z: prdata = {21'd0, dim_z_reg};
            REG_WRAP:  prdata = {31'd0, wrap_reg};
            REG_MASK:  prdata = {31'd0, use_mask_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg    <= 11'd32;
            dim_y_reg    <= 11'd32;
            dim_z_reg    <= 11'd32;
            wrap_reg     <= 1'b0;
            use_mask_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_DIM_X: dim_x_reg    <= pwdata[10:0];
                REG_DIM_Y: dim_y_reg    <= pwdata[10:0];
                REG_DIM_Z: dim_z_reg    <= pwdata[10:0];
                REG_WRAP:  wrap_reg     <= pwdata[0];
                REG_MASK:  use_mask_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // effective sizes and neighbourhood shape
    assign dx     = eff_dim(dim_x_reg);
    assign dy     = eff_dim(dim_y_reg);
    assign dz     = eff_dim(dim_z_reg);
    assign two_d  = (dz == 11'd1);
    assign k_last = two_d ? NB_LAST_2D : NB_LAST_3D;

    assign rd_label = ram_rdata[LB-1:0];
    assign rd_mask  = ram_rdata[LB];
    assign nb_rd    = nb_lab_reg[ptr_reg];
    assign in_range = (IDXW'(idx_reg) < total_reg) && (IDXW'(idx_reg) < MAX_W);
    assign e2       = $signed({1'b0, same_reg}) - $signed({1'b0, ccount_reg});
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign nbr_ctx = '{two_d: two_d, wrap: wrap_reg, dx: dx, dy: dy, dz: dz, xy: xy_reg,
                       x: x_reg, y: y_reg, z: z_reg, k: k_reg};

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        lab_next        = lab_reg;
        msk_next        = msk_reg;
        choice_next     = choice_reg;
        xy_next         = xy_reg;
        total_next      = total_reg;
        spin_next       = spin_reg;
        smask_next      = smask_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        k_next          = k_reg;
        ncount_next     = ncount_reg;
        same_next       = same_reg;
        ptr_next        = ptr_reg;
        ccount_next     = ccount_reg;
        cand_next       = cand_reg;
        res_status_next = res_status_reg;
        res_label_next  = res_label_reg;
        res_e2_next     = res_e2_reg;
        flip_cnt_next   = flip_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_load          = 1'b0;
        nb_we           = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = AW'(idx_reg);
        ram_wdata       = {msk_reg, lab_reg};
        div_req         = '{start: 1'b0, dividend: idx_reg, divisor: dx};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next    = s_command;
                    idx_next    = s_cell_index;
                    lab_next    = LB'(s_cell_label);
                    msk_next    = s_cell_mask;
                    choice_next = s_neighbor_choice;
                    ncount_next = 5'd0;
                    res_e2_next = 6'sd0;
                    state_next  = S_XY;
                end
            end
            S_XY: begin
                xy_next    = 21'(dx * dy);
                state_next = S_TOT;
            end
            S_TOT: begin
                total_next = 31'(xy_reg * dz);
                state_next = S_CHK;
            end
            S_CHK: begin
                if (cmd_reg == CMD_RSVD || !in_range) begin
                    res_status_next = ST_RANGE;
                    res_label_next  = '0;
                    state_next      = S_EMIT;
                end else if (cmd_reg == CMD_WRITE) begin
                    ram_we          = 1'b1;
                    res_status_next = ST_WRITTEN;
                    res_label_next  = lab_reg;
                    state_next      = S_EMIT;
                end else begin
                    state_next = S_SITE;
                end
            end
            S_SITE: begin
                res_label_next = rd_label;
                spin_next      = rd_label;
                smask_next     = rd_mask;
                if (cmd_reg == CMD_READ) begin
                    res_status_next = ST_READ;
                    state_next      = S_EMIT;
                end else if (rd_label == '0 || (use_mask_reg && !rd_mask)) begin
                    res_status_next = ST_SKIPPED;
                    state_next      = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    x_next        = div_rsp.rem[9:0];
                    div_req       = '{start: 1'b1, dividend: div_rsp.quot, divisor: dy};
                    state_next    = S_DIV2;
                end
            end
            S_DIV2: begin
                div_req.divisor = dy;
                if (div_rsp.done) begin
                    y_next      = div_rsp.rem[9:0];
                    z_next      = div_rsp.quot[9:0];
                    k_next      = 5'd0;
                    same_next   = 5'd0;
                    state_next  = S_NB1;
                end
            end
            S_NB1: state_next = S_NB2;
            S_NB2: state_next = S_NB3;
            S_NB3: begin
                ram_addr = AW'(nbr_rsp.index);
                if (nbr_rsp.ok) begin
                    state_next = S_NB4;
                end else if (k_reg == k_last) begin
                    state_next = S_EVAL;
                end else begin
                    k_next     = k_reg + 5'd1;
                    state_next = S_NB1;
                end
            end
            S_NB4: begin
                if (!(use_mask_reg && !rd_mask)) begin
                    nb_we       = 1'b1;
                    ncount_next = ncount_reg + 5'd1;
                    if (rd_label == spin_reg) same_next = same_reg + 5'd1;
                end
                if (k_reg == k_last) begin
                    state_next = S_EVAL;
                end else begin
                    k_next     = k_reg + 5'd1;
                    state_next = S_NB1;
                end
            end
            S_EVAL: begin
                res_label_next = spin_reg;
                if (same_reg == ncount_reg) begin
                    res_status_next = ST_UNIFORM;
                    state_next      = S_EMIT;
                end else begin
                    div_req    = '{start: 1'b1, dividend: 15'(choice_reg),
                                   divisor: 11'(ncount_reg)};
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                div_req.divisor = 11'(ncount_reg);
                if (div_rsp.done) begin
                    ptr_next   = div_rsp.rem[4:0];
                    state_next = S_CAND;
                end
            end
            S_CAND: begin
                cand_next   = nb_rd;
                ptr_next    = 5'd0;
                ccount_next = 5'd0;
                if (nb_rd == '0) begin
                    res_status_next = ST_VOID;
                    state_next      = S_EMIT;
                end else if (nb_rd == spin_reg) begin
                    res_status_next = ST_SAME;
                    state_next      = S_EMIT;
                end else begin
                    state_next = S_ENER;
                end
            end
            S_ENER: begin
                if (nb_rd == cand_reg) ccount_next = ccount_reg + 5'd1;
                if (ptr_reg == ncount_reg - 5'd1) state_next = S_DEC;
                else ptr_next = ptr_reg + 5'd1;
            end
            S_DEC: begin
                res_e2_next = e2;
                if (e2[5] || e2 == 6'sd0) begin
                    ram_we          = 1'b1;
                    ram_wdata       = {smask_reg, cand_reg};
                    res_status_next = ST_FLIPPED;
                    res_label_next  = cand_reg;
                    if (flip_cnt_reg != 32'hFFFF_FFFF) flip_cnt_next = flip_cnt_reg + 32'd1;
                end else begin
                    res_status_next = ST_REJECT;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            flip_cnt_reg <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            flip_cnt_reg <= flip_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        lab_reg        <= lab_next;
        msk_reg        <= msk_next;
        choice_reg     <= choice_next;
        xy_reg         <= xy_next;
        total_reg      <= total_next;
        spin_reg       <= spin_next;
        smask_reg      <= smask_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        k_reg          <= k_next;
        ncount_reg     <= ncount_next;
        same_reg       <= same_next;
        ptr_reg        <= ptr_next;
        ccount_reg     <= ccount_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_label_reg  <= res_label_next;
        res_e2_reg     <= res_e2_next;
        if (nb_we) nb_lab_reg[ncount_reg] <= rd_label;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_label_reg  <= 16'(res_label_reg);
            m_flip_reg   <= flip_cnt_reg;
            m_ncount_reg <= ncount_reg;
            m_e2_reg     <= res_e2_reg;
        end
    end

    // result channel
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_label_out      = m_label_reg;
    assign m_flip_count     = m_flip_reg;
    assign m_neighbor_count = m_ncount_reg;
    assign m_energy_twice   = m_e2_reg;

    // one transaction in flight at a time
    `PFE_ASSERT_NXT(a_single_item, aclk, aresetn, accept, !s_ready)
    // the lattice is written only by a write command or an accepted flip
    `PFE_ASSERT_IMP(a_ram_write_state, aclk, aresetn, ram_we, (state_reg == S_CHK || state_reg == S_DEC))
    // flip counter moves only on a flip decision
    `PFE_ASSERT_IMP(a_flip_count_src, aclk, aresetn, !$stable(flip_cnt_reg) && $past(aresetn), $past(state_reg) == S_DEC)
    // neighbour count never exceeds the 3D neighbourhood
    `PFE_ASSERT_IMP(a_ncount_bound, aclk, aresetn, 1'b1, ncount_reg <= NB_MAX)

endmodule

/* tb/potts_lattice_flip_engine_tb.sv */
// self-checking testbench of the lattice flip engine: directed table, then random phases
// depends on pfe_pkg and potts_lattice_flip_engine; an inline predictor checks every result
module potts_lattice_flip_engine_tb;
    import pfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS      = 32768;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic [3:0]        status;
        logic [15:0]       label_out;
        logic [31:0]       flip_count;
        logic [4:0]        neighbor_count;
        logic signed [5:0] energy_twice;
    } cell_result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] idx;
        logic [15:0] lab;
        logic        msk;
        logic [4:0]  choice;
        logic        typed;
        logic [3:0]  t_status;
        logic [15:0] t_label;
    } stim_row_t;

    // neighbour offsets in scan order
    localparam int OX2 [8] = '{1, -1, 0, 0, 1, -1, 1, -1};
    localparam int OY2 [8] = '{0, 0, 1, -1, 1, 1, -1, -1};
    localparam int OX3 [26] = '{1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, 1, -1, -1,
                                0, 0, 0, 0, 1, 1, 1, 1, -1, -1, -1, -1};
    localparam int OY3 [26] = '{0, 0, 1, -1, 0, 0, 1, 1, -1, -1, 0, 0, 0, 0,
                                1, 1, -1, -1, 1, 1, -1, -1, 1, 1, -1, -1};
    localparam int OZ3 [26] = '{0, 0, 0, 0, 1, -1, 0, 0, 0, 0, 1, -1, 1, -1,
                                1, -1, 1, -1, 1, -1, 1, -1, 1, -1, 1, -1};

    // directed table; rows from index 5 on run on a 4x4 2D lattice of label 1
    localparam int DIR_ROWS  = 21;
    localparam int DIR_SPLIT = 5;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_WRITE, 15'd32767, 16'hFFFF, 1'b1, 5'd0,  1'b1, ST_WRITTEN, 16'hFFFF},
        '{CMD_WRITE, 15'd0,     16'h0000, 1'b0, 5'd0,  1'b1, ST_WRITTEN, 16'h0000},
        '{CMD_RSVD,  15'd5,     16'h1234, 1'b1, 5'd7,  1'b1, ST_RANGE,   16'h0000},
        '{CMD_READ,  15'd32767, 16'h0000, 1'b0, 5'd0,  1'b1, ST_READ,    16'hFFFF},
        '{CMD_FLIP,  15'd0,     16'h0000, 1'b0, 5'd0,  1'b1, ST_SKIPPED, 16'h0000},
        '{CMD_FLIP,  15'd5,     16'h0000, 1'b0, 5'd0,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_WRITE, 15'd6,     16'h0002, 1'b1, 5'd0,  1'b1, ST_WRITTEN, 16'h0002},
        '{CMD_FLIP,  15'd5,     16'h0000, 1'b0, 5'd0,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_FLIP,  15'd6,     16'h0000, 1'b0, 5'd0,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_WRITE, 15'd9,     16'h0000, 1'b1, 5'd0,  1'b1, ST_WRITTEN, 16'h0000},
        '{CMD_WRITE, 15'd10,    16'h0003, 1'b1, 5'd0,  1'b1, ST_WRITTEN, 16'h0003},
        '{CMD_FLIP,  15'd10,    16'h0000, 1'b0, 5'd1,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_FLIP,  15'd10,    16'h0000, 1'b0, 5'd0,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_WRITE, 15'd14,    16'h0004, 1'b1, 5'd0,  1'b1, ST_WRITTEN, 16'h0004},
        '{CMD_FLIP,  15'd10,    16'h0000, 1'b0, 5'd2,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_FLIP,  15'd15,    16'h0000, 1'b0, 5'd31, 1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_WRITE, 15'd0,     16'hFFFF, 1'b0, 5'd0,  1'b1, ST_WRITTEN, 16'hFFFF},
        '{CMD_FLIP,  15'd0,     16'h0000, 1'b0, 5'd3,  1'b0, ST_WRITTEN, 16'h0000},
        '{CMD_READ,  15'd16,    16'h0000, 1'b0, 5'd0,  1'b1, ST_RANGE,   16'h0000},
        '{CMD_FLIP,  15'd32767, 16'hFFFF, 1'b1, 5'd31, 1'b1, ST_RANGE,   16'h0000},
        '{CMD_RSVD,  15'd3,     16'h0000, 1'b0, 5'd0,  1'b1, ST_RANGE,   16'h0000}
    };

    // random phases: dim_x, dim_y, dim_z, wrap, mask as written to the registers
    localparam int PHASES = 10;
    localparam int PH_DX [PHASES] = '{1, 0, 3, 5, 2047, 1, 1, 4, 2, 6};
    localparam int PH_DY [PHASES] = '{1, 0, 3, 4, 1, 1, 1024, 4, 3, 5};
    localparam int PH_DZ [PHASES] = '{1, 0, 3, 1, 1, 1024, 1, 4, 2, 1};
    localparam int PH_WR [PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 0};
    localparam int PH_MK [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1, 1, 0};
    localparam int PH_ITEMS   = 130;
    localparam int HOLD_PHASE = 3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [14:0] s_cell_index = '0;
    logic [15:0] s_cell_label = '0;
    logic        s_cell_mask = 1'b0;
    logic [4:0]  s_neighbor_choice = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic [15:0] m_label_out;
    logic [31:0] m_flip_count;
    logic [4:0]  m_neighbor_count;
    logic signed [5:0] m_energy_twice;

    // predictor state
    logic [15:0] lat_label [CELLS];
    bit          lat_mask [CELLS];
    bit          lat_written [CELLS];
    logic [31:0] flip_total;
    int          cfg_dx, cfg_dy, cfg_dz, cfg_wrap, cfg_mask;

    cell_result_t expected_q [$];
    logic         cur_typed = 1'b0;
    logic [3:0]   cur_t_status = '0;
    logic [15:0]  cur_t_label = '0;
    int           err_count = 0;
    int           idle_cycles = 0;
    bit           quiet = 1'b0;
    int           phase_no = -1;
    bit           long_done = 1'b0;
    int           hold_left = 0;

    potts_lattice_flip_engine dut (.*);

    always #2 aclk = ~aclk;

    function automatic int eff_size(input int d);
        if (d == 0) return 1;
        if (d > 1024) return 1024;
        return d;
    endfunction

    function automatic longint lattice_cells();
        return longint'(eff_size(cfg_dx)) * eff_size(cfg_dy) * eff_size(cfg_dz);
    endfunction

    // one axis step; fails when the step leaves a clipped lattice
    function automatic bit step_axis(input int c, input int s, input int n, output int res);
        int v;
        v = c + s;
        if (v < 0) begin
            if (cfg_wrap == 0) return 1'b0;
            v += n;
        end else if (v >= n) begin
            if (cfg_wrap == 0) return 1'b0;
            v -= n;
        end
        res = v;
        return 1'b1;
    endfunction

    // applies one transaction to the predictor lattice and returns its result
    function automatic cell_result_t lattice_apply(input stim_row_t it);
        cell_result_t r;
        int dx, dy, dz, x, y, z, k, n_off, nx, ny, nz, cnt, same, e2, sx, sy, sz;
        int nb [26];
        longint ni;
        logic [15:0] spin, cand, nl;
        bit two_d;
        r = '0;
        r.status = ST_RANGE;
        dx = eff_size(cfg_dx);
        dy = eff_size(cfg_dy);
        dz = eff_size(cfg_dz);
        cnt = 0;
        e2 = 0;
        if (it.cmd != CMD_RSVD && longint'(it.idx) < longint'(dx) * dy * dz) begin
            if (it.cmd == CMD_WRITE) begin
                lat_label[it.idx] = it.lab;
                lat_mask[it.idx] = it.msk;
                lat_written[it.idx] = 1'b1;
                r.status = ST_WRITTEN;
            end else if (it.cmd == CMD_READ) begin
                r.status = ST_READ;
            end else begin
                spin = lat_label[it.idx];
                if (spin == 0 || (cfg_mask != 0 && !lat_mask[it.idx])) begin
                    r.status = ST_SKIPPED;
                end else begin
                    x = it.idx % dx;
                    y = (it.idx / dx) % dy;
                    z = it.idx / (dx * dy);
                    two_d = (dz == 1);
                    n_off = two_d ? 8 : 26;
                    for (k = 0; k < n_off; k++) begin
                        sx = two_d ? OX2[k] : OX3[k];
                        sy = two_d ? OY2[k] : OY3[k];
                        sz = two_d ? 0 : OZ3[k];
                        if (!step_axis(x, sx, dx, nx)) continue;
                        if (!step_axis(y, sy, dy, ny)) continue;
                        if (!step_axis(z, sz, dz, nz)) continue;
                        ni = longint'(nz) * dy * dx + longint'(ny) * dx + nx;
                        if (ni >= CELLS) continue;
                        if (cfg_mask != 0 && !lat_mask[ni]) continue;
                        nb[cnt] = int'(ni);
                        cnt++;
                    end
                    same = 0;
                    for (k = 0; k < cnt; k++)
                        if (lat_label[nb[k]] == spin) same++;
                    if (same == cnt) begin
                        r.status = ST_UNIFORM;
                    end else begin
                        cand = lat_label[nb[it.choice % cnt]];
                        if (cand == 0) begin
                            r.status = ST_VOID;
                        end else if (cand == spin) begin
                            r.status = ST_SAME;
                        end else begin
                            for (k = 0; k < cnt; k++) begin
                                nl = lat_label[nb[k]];
                                e2 += (nl != cand) ? 1 : 0;
                                e2 -= (nl != spin) ? 1 : 0;
                            end
                            if (e2 <= 0) begin
                                lat_label[it.idx] = cand;
                                if (flip_total != 32'hFFFF_FFFF) flip_total++;
                                r.status = ST_FLIPPED;
                            end else begin
                                r.status = ST_REJECT;
                            end
                        end
                    end
                end
            end
            r.label_out = lat_label[it.idx];
        end
        r.flip_count = flip_total;
        r.neighbor_count = cnt[4:0];
        r.energy_twice = e2[5:0];
        return r;
    endfunction

    // label mix: mostly a few grains, some voids, some full-width values
    function automatic logic [15:0] rand_label();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'($urandom);
        return 16'($urandom_range(1, 3));
    endfunction

    // transaction tracking, prediction and checking
    always @(posedge aclk) begin
        stim_row_t it;
        cell_result_t ex;
        if (aresetn && s_valid && s_ready) begin
            it = '{s_command, s_cell_index, s_cell_label, s_cell_mask, s_neighbor_choice,
                   cur_typed, cur_t_status, cur_t_label};
            ex = lattice_apply(it);
            if (cur_typed) begin
                ex.status = cur_t_status;
                ex.label_out = cur_t_label;
            end
            expected_q.push_back(ex);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no transaction pending, status %0d", m_status);
                err_count++;
            end else begin
                ex = expected_q.pop_front();
                if (m_status !== ex.status) begin
                    $error("status exp %0d got %0d", ex.status, m_status);
                    err_count++;
                end
                if (m_label_out !== ex.label_out) begin
                    $error("label_out exp %0d got %0d", ex.label_out, m_label_out);
                    err_count++;
                end
                if (m_flip_count !== ex.flip_count) begin
                    $error("flip_count exp %0d got %0d", ex.flip_count, m_flip_count);
                    err_count++;
                end
                if (m_neighbor_count !== ex.neighbor_count) begin
                    $error("neighbor_count exp %0d got %0d", ex.neighbor_count,
                           m_neighbor_count);
                    err_count++;
                end
                if (m_energy_twice !== ex.energy_twice) begin
                    $error("energy_twice exp %0d got %0d", ex.energy_twice, m_energy_twice);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side backpressure: random stall bursts, one long hold-off
    always @(negedge aclk) begin
        if (phase_no == HOLD_PHASE && !long_done) begin
            long_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (quiet || $urandom_range(0, 4) != 0) begin
            m_ready <= 1'b1;
        end else begin
            hold_left <= $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end
    end

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_lattice(input int dx, input int dy, input int dz, input int wr,
                               input int mk);
        apb_write(REG_DIM_X, 32'(dx));
        apb_write(REG_DIM_Y, 32'(dy));
        apb_write(REG_DIM_Z, 32'(dz));
        apb_write(REG_WRAP, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, 1'(wr)});
        apb_write(REG_MASK, 32'(mk));
        cfg_dx = dx & 32'h7FF;
        cfg_dy = dy & 32'h7FF;
        cfg_dz = dz & 32'h7FF;
        cfg_wrap = wr;
        cfg_mask = mk;
    endtask

    // offers one transaction, sometimes after a random gap, and waits for acceptance
    task automatic send_cell(input stim_row_t it);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= it.cmd;
        s_cell_index <= it.idx;
        s_cell_label <= it.lab;
        s_cell_mask <= it.msk;
        s_neighbor_choice <= it.choice;
        cur_typed <= it.typed;
        cur_t_status <= it.t_status;
        cur_t_label <= it.t_label;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // stop offering and let every pending result come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // write every cell of the lattice, or only the ones never written
    task automatic fill_lattice(input bit fixed);
        stim_row_t it;
        int i;
        for (i = 0; i < lattice_cells() && i < CELLS; i++) begin
            if (fixed || !lat_written[i]) begin
                it = '0;
                it.cmd = CMD_WRITE;
                it.idx = 15'(i);
                it.lab = fixed ? 16'd1 : 16'($urandom_range(0, 7) == 0 ? 0 :
                                          $urandom_range(1, 3));
                it.msk = fixed ? 1'b1 : ($urandom_range(0, 3) != 0);
                send_cell(it);
            end
        end
    endtask

    initial begin
        stim_row_t it;
        int p, n, r;
        longint cells;
        flip_total = '0;
        cfg_dx = 32;
        cfg_dy = 32;
        cfg_dz = 32;
        cfg_wrap = 0;
        cfg_mask = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed table
        for (n = 0; n < DIR_ROWS; n++) begin
            if (n == DIR_SPLIT) begin
                drain();
                set_lattice(4, 4, 1, 0, 0);
                fill_lattice(1'b1);
            end
            send_cell(DIR_TABLE[n]);
        end
        drain();

        // random phases over several lattice shapes
        for (p = 0; p < PHASES; p++) begin
            set_lattice(PH_DX[p], PH_DY[p], PH_DZ[p], PH_WR[p], PH_MK[p]);
            fill_lattice(1'b0);
            quiet = (p == PHASES - 1);
            phase_no = p;
            cells = lattice_cells();
            for (n = 0; n < PH_ITEMS; n++) begin
                it = '0;
                r = $urandom_range(0, 19);
                if (r < 12) it.cmd = CMD_FLIP;
                else if (r < 16) it.cmd = CMD_WRITE;
                else if (r < 19) it.cmd = CMD_READ;
                else it.cmd = CMD_RSVD;
                if ($urandom_range(0, 9) == 0) it.idx = 15'($urandom);
                else it.idx = 15'($urandom_range(0, int'(cells) - 1));
                it.lab = rand_label();
                it.msk = ($urandom_range(0, 3) != 0);
                it.choice = 5'($urandom);
                send_cell(it);
            end
            drain();
        end

        repeat (50) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/pfe_pkg.sv
sv/pfe_ram.sv
sv/pfe_div.sv
sv/pfe_nbr.sv
sv/potts_lattice_flip_engine.sv
tb/potts_lattice_flip_engine_tb.sv
